>>> src/lmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap mark detector package
// Shared types, codes and constants for the lap mark detector.
// ----------------------------------------------------------------------------
package lmd_pkg;

	// Command codes carried in the mode field
	typedef enum logic [2:0] {
		MODE_TICK     = 3'd0,
		MODE_FRAME    = 3'd1,
		MODE_ARM      = 3'd2,
		MODE_START    = 3'd3,
		MODE_STOP     = 3'd4,
		MODE_TIMER_EN = 3'd5
	} mode_t;

	// Lap phase
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1,
		PH_RUN  = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_MARK_TOTAL_MIN   = 3'd0,
		REG_MARK_SPAN_MIN    = 3'd1,
		REG_CONFIRM_NEEDED   = 3'd2,
		REG_MIN_LAP_TIME     = 3'd3,
		REG_MIN_LAP_DISTANCE = 3'd4,
		REG_FINISH_TOTAL_MIN = 3'd5,
		REG_FINISH_SPAN_MIN  = 3'd6,
		REG_LEAVE_FRAMES     = 3'd7
	} cfg_idx_t;

	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [7:0]  CNT_MAX    = 8'hFF;
	localparam logic [31:0] U32_MAX    = 32'hFFFF_FFFF;
	localparam logic [3:0]  BASE_INIT  = 4'd1;

	typedef struct packed {
		logic [3:0]  mark_total_min;
		logic [3:0]  mark_span_min;
		logic [7:0]  confirm_needed;
		logic [15:0] min_lap_time;
		logic [31:0] min_lap_distance;
		logic [3:0]  finish_total_min;
		logic [3:0]  finish_span_min;
		logic [7:0]  leave_frames;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic [7:0]         sensor_bits;
		logic signed [15:0] enc_left;
		logic signed [15:0] enc_right;
		logic               tracking_on;
		logic               option_bit;
	} item_t;

	typedef struct packed {
		logic [1:0]  lap_phase;
		logic [31:0] elapsed_ms;
		logic [31:0] distance_count;
		logic        start_pulse;
		logic        finish_pulse;
		logic        left_start;
		logic [7:0]  confirm_count;
		logic        timer_running;
	} result_t;

	// Frame score: set-bit count and span from lowest to highest set bit
	typedef struct packed {
		logic [3:0] total;
		logic [3:0] span;
	} score_t;

endpackage

>>> src/lmd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap mark detector configuration registers
// Holds the detection thresholds, written one register per transaction.
// ----------------------------------------------------------------------------
module lmd_cfg_regs import lmd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [2:0]            wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mark_total_min   <= 4'd4;
			cfg_q.mark_span_min    <= 4'd5;
			cfg_q.confirm_needed   <= 8'd3;
			cfg_q.min_lap_time     <= 16'd5000;
			cfg_q.min_lap_distance <= 32'd0;
			cfg_q.finish_total_min <= 4'd5;
			cfg_q.finish_span_min  <= 4'd6;
			cfg_q.leave_frames     <= 8'd5;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				REG_MARK_TOTAL_MIN:   cfg_q.mark_total_min   <= wr_data[3:0];
				REG_MARK_SPAN_MIN:    cfg_q.mark_span_min    <= wr_data[3:0];
				REG_CONFIRM_NEEDED:   cfg_q.confirm_needed   <= wr_data[7:0];
				REG_MIN_LAP_TIME:     cfg_q.min_lap_time     <= wr_data[15:0];
				REG_MIN_LAP_DISTANCE: cfg_q.min_lap_distance <= wr_data[31:0];
				REG_FINISH_TOTAL_MIN: cfg_q.finish_total_min <= wr_data[3:0];
				REG_FINISH_SPAN_MIN:  cfg_q.finish_span_min  <= wr_data[3:0];
				REG_LEAVE_FRAMES:     cfg_q.leave_frames     <= wr_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/lmd_frame_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap mark detector frame score
// Counts set sensor bits and measures their span over the active sensors.
// ----------------------------------------------------------------------------
module lmd_frame_score import lmd_pkg::*; #(
	parameter int SENSOR_COUNT = 8
) (
	input  logic [7:0] sensor_bits,
	output score_t     score
);

	logic [3:0] total;
	logic [2:0] first;
	logic [2:0] last;
	logic       any;

	always_comb begin
		total = '0;
		first = '0;
		last  = '0;
		any   = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (i < SENSOR_COUNT && sensor_bits[i]) begin
				total = total + 4'd1;
				if (!any) begin
					first = 3'(i);
				end
				any  = 1'b1;
				last = 3'(i);
			end
		end
	end

	assign score.total = total;
	assign score.span  = any ? (4'(last) - 4'(first) + 4'd1) : 4'd0;

endmodule

>>> src/lmd_lap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap mark detector lap core
// Lap state registers and the next-state logic for one command item.
// ----------------------------------------------------------------------------
module lmd_lap_core import lmd_pkg::*; #(
	parameter int JUMP_TOTAL     = 2,
	parameter int JUMP_SPAN      = 2,
	parameter int BASELINE_ALPHA = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  score_t  score,
	input  cfg_t    cfg,
	output result_t result
);

	localparam int NUM_W = $clog2(8 * BASELINE_ALPHA + 1);

	typedef struct packed {
		phase_t      phase;
		logic [31:0] run_ms;
		logic        timer_on;
		logic [31:0] odometer;
		logic [7:0]  confirm;
		logic [7:0]  leave;
		logic        has_left;
		logic [3:0]  base_total;
		logic [3:0]  base_span;
	} lap_state_t;

	lap_state_t st_q;
	lap_state_t nxt;
	logic       start_p;
	logic       finish_p;

	function automatic lap_state_t clear_lap(lap_state_t s);
		lap_state_t r;
		r            = s;
		r.confirm    = '0;
		r.leave      = '0;
		r.has_left   = 1'b0;
		r.odometer   = '0;
		r.base_total = BASE_INIT;
		r.base_span  = BASE_INIT;
		return r;
	endfunction

	// Smoothed baseline: (old * (ALPHA - 1) + sample) / ALPHA, result at most 8
	function automatic logic [3:0] smooth(logic [3:0] old, logic [3:0] sample);
		logic [NUM_W-1:0] num;
		logic [3:0]       q;
		num = NUM_W'(old) * NUM_W'(BASELINE_ALPHA - 1) + NUM_W'(sample);
		q   = '0;
		for (int k = 1; k <= 8; k++) begin
			if (num >= NUM_W'(k * BASELINE_ALPHA)) begin
				q = q + 4'd1;
			end
		end
		return q;
	endfunction

	// Odometer step: (|left| + |right|) / 2, saturating add
	logic [16:0] abs_l;
	logic [16:0] abs_r;
	logic [16:0] abs_sum;
	logic [32:0] odo_sum;
	logic [31:0] odo_sat;
	logic [31:0] odo_after;

	assign abs_l   = item.enc_left[15] ? (17'h10000 - 17'(item.enc_left[15:0]))
	                                   : 17'(item.enc_left[15:0]);
	assign abs_r   = item.enc_right[15] ? (17'h10000 - 17'(item.enc_right[15:0]))
	                                    : 17'(item.enc_right[15:0]);
	assign abs_sum = abs_l + abs_r;
	assign odo_sum = 33'(st_q.odometer) + 33'(abs_sum[16:1]);
	assign odo_sat = odo_sum[32] ? U32_MAX : odo_sum[31:0];
	assign odo_after = (st_q.phase == PH_RUN) ? odo_sat : st_q.odometer;

	// Mark tests
	logic cand, fcand, time_ok, odom_ok, jump, hit, conf_hit;
	logic [7:0] cf_inc;
	logic [7:0] lc_inc;

	assign cand    = (score.total >= cfg.mark_total_min) && (score.span >= cfg.mark_span_min);
	assign fcand   = (score.total >= cfg.finish_total_min) &&
	                 (score.span >= cfg.finish_span_min);
	assign time_ok = st_q.run_ms >= 32'(cfg.min_lap_time);
	assign odom_ok = odo_after >= cfg.min_lap_distance;
	assign jump    = (5'(score.total) >= 5'(st_q.base_total) + 5'(JUMP_TOTAL)) ||
	                 (5'(score.span) >= 5'(st_q.base_span) + 5'(JUMP_SPAN));
	assign hit     = fcand && time_ok && odom_ok && jump;
	assign conf_hit = (st_q.phase == PH_WAIT && cand) ||
	                  (st_q.phase == PH_RUN && st_q.has_left && hit);
	assign cf_inc  = (st_q.confirm != CNT_MAX) ? st_q.confirm + 8'd1 : st_q.confirm;
	assign lc_inc  = (st_q.leave != CNT_MAX) ? st_q.leave + 8'd1 : st_q.leave;

	always_comb begin
		nxt      = st_q;
		start_p  = 1'b0;
		finish_p = 1'b0;
		case (mode_t'(item.mode))
			MODE_TICK: begin
				if (st_q.timer_on && st_q.run_ms != U32_MAX) begin
					nxt.run_ms = st_q.run_ms + 32'd1;
				end
			end
			MODE_FRAME: begin
				nxt.odometer = odo_after;
				if (item.tracking_on && (st_q.phase == PH_WAIT || st_q.phase == PH_RUN)) begin
					if (st_q.phase == PH_RUN && st_q.has_left && !hit &&
					    (!time_ok || !odom_ok || !fcand)) begin
						nxt.base_total = smooth(st_q.base_total, score.total);
						nxt.base_span  = smooth(st_q.base_span, score.span);
					end
					nxt.confirm = conf_hit ? cf_inc : 8'd0;
					if (st_q.phase == PH_RUN) begin
						nxt.leave = (cand || fcand) ? 8'd0 : lc_inc;
					end
					if (st_q.phase == PH_WAIT) begin
						if (nxt.confirm >= cfg.confirm_needed) begin
							nxt          = clear_lap(nxt);
							nxt.run_ms   = '0;
							nxt.timer_on = 1'b1;
							nxt.phase    = PH_RUN;
							start_p      = 1'b1;
						end
					end else begin
						nxt.has_left = st_q.has_left || (nxt.leave >= cfg.leave_frames);
						if (nxt.has_left && hit && nxt.confirm >= cfg.confirm_needed) begin
							nxt.timer_on = 1'b0;
							nxt.phase    = PH_DONE;
							finish_p     = 1'b1;
						end
					end
				end
			end
			MODE_ARM: begin
				nxt        = clear_lap(st_q);
				nxt.run_ms = '0;
				nxt.phase  = item.option_bit ? PH_WAIT : PH_IDLE;
			end
			MODE_START: begin
				nxt          = clear_lap(st_q);
				nxt.run_ms   = '0;
				nxt.timer_on = 1'b1;
				nxt.phase    = PH_RUN;
			end
			MODE_STOP: begin
				nxt          = clear_lap(st_q);
				nxt.timer_on = 1'b0;
				nxt.phase    = PH_IDLE;
			end
			MODE_TIMER_EN: begin
				nxt.timer_on = item.option_bit;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= PH_IDLE;
			st_q.run_ms     <= '0;
			st_q.timer_on   <= 1'b0;
			st_q.odometer   <= '0;
			st_q.confirm    <= '0;
			st_q.leave      <= '0;
			st_q.has_left   <= 1'b0;
			st_q.base_total <= BASE_INIT;
			st_q.base_span  <= BASE_INIT;
		end else if (fire) begin
			st_q <= nxt;
		end
	end

	assign result.lap_phase      = nxt.phase;
	assign result.elapsed_ms     = nxt.run_ms;
	assign result.distance_count = nxt.odometer;
	assign result.start_pulse    = start_p;
	assign result.finish_pulse   = finish_p;
	assign result.left_start     = nxt.has_left;
	assign result.confirm_count  = nxt.confirm;
	assign result.timer_running  = nxt.timer_on;

endmodule

>>> src/lap_mark_detector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap mark detector top level
// Follows a timed lap from line-sensor frames and command items: phase,
// run timer, odometer and start / finish event pulses.
//
//   Channel   Direction  Handshake           Payload
//   input     in         in_valid/in_stall   mode, sensor_bits, enc_left,
//                                            enc_right, tracking_on, option_bit
//   output    out        out_valid/out_stall lap_phase, elapsed_ms, distance_count,
//                                            start_pulse, finish_pulse, left_start,
//                                            confirm_count, timer_running
//   config    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One transaction in gives one transaction out: the item is held in the input
// register and its result in the result register, which offers it. A new item
// is taken every cycle while the output is not stalled: the input register feeds
// the lap state logic, whose single combinational pass sets the state registers
// and the result register in the same edge. Reset puts the lap in idle with timer
// and odometer at zero. An output stall holds the result register and then the
// input register; in_stall rises only when both are full and the output is stalled.
// ----------------------------------------------------------------------------
module lap_mark_detector_top import lmd_pkg::*; #(
	parameter int JUMP_TOTAL     = 2,
	parameter int JUMP_SPAN      = 2,
	parameter int BASELINE_ALPHA = 8,
	parameter int SENSOR_COUNT   = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [2:0]            mode,
	input  logic [7:0]            sensor_bits,
	input  logic signed [15:0]    enc_left,
	input  logic signed [15:0]    enc_right,
	input  logic                  tracking_on,
	input  logic                  option_bit,
	// output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            lap_phase,
	output logic [31:0]           elapsed_ms,
	output logic [31:0]           distance_count,
	output logic                  start_pulse,
	output logic                  finish_pulse,
	output logic                  left_start,
	output logic [7:0]            confirm_count,
	output logic                  timer_running,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	result_t res_next;
	score_t  score;
	cfg_t    cfg;
	logic    advance;
	logic    in_take;

	// Registers are always writable; write them only while no transaction is in flight.
	assign cfg_ready = 1'b1;

	lmd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Advance the held item into the lap logic when the result register is free
	// or being emptied this cycle.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.mode        <= mode;
			item_s1.sensor_bits <= sensor_bits;
			item_s1.enc_left    <= enc_left;
			item_s1.enc_right   <= enc_right;
			item_s1.tracking_on <= tracking_on;
			item_s1.option_bit  <= option_bit;
		end
	end

	lmd_frame_score #(
		.SENSOR_COUNT (SENSOR_COUNT)
	) u_score (
		.sensor_bits (item_s1.sensor_bits),
		.score       (score)
	);

	lmd_lap_core #(
		.JUMP_TOTAL     (JUMP_TOTAL),
		.JUMP_SPAN      (JUMP_SPAN),
		.BASELINE_ALPHA (BASELINE_ALPHA)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.score  (score),
		.cfg    (cfg),
		.result (res_next)
	);

	// Result register: load on advance, drop once the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid      = valid_s2;
	assign lap_phase      = res_s2.lap_phase;
	assign elapsed_ms     = res_s2.elapsed_ms;
	assign distance_count = res_s2.distance_count;
	assign start_pulse    = res_s2.start_pulse;
	assign finish_pulse   = res_s2.finish_pulse;
	assign left_start     = res_s2.left_start;
	assign confirm_count  = res_s2.confirm_count;
	assign timer_running  = res_s2.timer_running;

endmodule
